/* rtl/tlce_pkg.sv */
package tlce_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int VAL_W         = 32;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_SECOND = 2'd1;
    localparam logic [1:0] ACT_THIRD  = 2'd2;
    localparam logic [1:0] ACT_PROBE  = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] key;
        logic             valid;
        logic             second;
        logic             third;
        logic             reported;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic shift;
        logic mark_second;
        logic mark_third;
        logic mark_reported;
    } t_upd;

endpackage

/* rtl/tlce_cell.sv */
module tlce_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmp_en,
    input  logic [tlce_pkg::VAL_W-1:0] i_key,
    input  tlce_pkg::t_upd            i_upd,
    input  tlce_pkg::t_entry          i_prev,
    output tlce_pkg::t_entry          o_entry,
    output logic                      o_hit,
    output logic                      o_common
);
    import tlce_pkg::*;

    logic [VAL_W-1:0] r_key;
    logic             r_valid;
    logic             r_second;
    logic             r_third;
    logic             r_reported;
    logic             r_hit;
    logic             r_common;
    logic             w_match;

    assign w_match = r_valid && (r_key == i_key);

    always_ff @(posedge i_clk) begin
        if (i_upd.shift) begin
            r_key <= i_prev.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_second   <= 1'b0;
            r_third    <= 1'b0;
            r_reported <= 1'b0;
        end else if (i_upd.clear) begin
            r_valid    <= 1'b0;
            r_second   <= 1'b0;
            r_third    <= 1'b0;
            r_reported <= 1'b0;
        end else if (i_upd.shift) begin
            r_valid    <= i_prev.valid;
            r_second   <= i_prev.second;
            r_third    <= i_prev.third;
            r_reported <= i_prev.reported;
        end else if (r_hit) begin
            r_second   <= r_second | i_upd.mark_second;
            r_third    <= r_third | i_upd.mark_third;
            r_reported <= r_reported | (i_upd.mark_reported & r_common);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit    <= 1'b0;
            r_common <= 1'b0;
        end else if (i_cmp_en) begin
            r_hit    <= w_match;
            r_common <= w_match && r_second && r_third && !r_reported;
        end
    end

    assign o_entry.key      = r_key;
    assign o_entry.valid    = r_valid;
    assign o_entry.second   = r_second;
    assign o_entry.third    = r_third;
    assign o_entry.reported = r_reported;
    assign o_hit            = r_hit;
    assign o_common         = r_common;

endmodule

/* rtl/three_list_common_elements.sv */
// Three-way set intersection over a row of key cells.
// Input channel: i_valid / o_stall carry one item (i_action, i_item_value).
//   Action clear empties the table, second and third insert a key or set its
//   list mark, probe asks whether the key is in both lists and not yet reported.
// Output channel: o_valid / i_stall carry one result per item: the echoed
//   value, o_is_common (first report of a common key) and o_status (insert
//   dropped, table full).
// Every cell compares its key with the incoming value on the accept edge; the
//   update state then combines the cell flags, updates marks or shifts a new key
//   into the head of the row, and loads the output register.
// The block takes no new item until the previous one is through the
//   compare-then-update pass through the cell row. The update waits while a
//   previous result is held and i_stall is high; the input stalls meanwhile.
// Reset empties the table and the output register; the block can take an item
//   straight after reset.
module three_list_common_elements (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_action,
    input  logic signed [tlce_pkg::VAL_W-1:0] i_item_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [tlce_pkg::VAL_W-1:0] o_result_value,
    output logic                             o_is_common,
    output logic                             o_status
);
    import tlce_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic                     r_state;
    logic [1:0]               r_act;
    logic signed [VAL_W-1:0]  r_val;
    logic [CNT_W-1:0]         r_count;
    logic                     r_ov;
    logic signed [VAL_W-1:0]  r_o_val;
    logic                     r_o_common;
    logic                     r_o_status;

    logic                     w_accept;
    logic                     w_adv;
    logic                     w_insert;
    logic                     w_full;
    logic                     w_any_hit;
    logic                     w_any_common;
    t_upd                     w_upd;
    t_entry                   w_new;
    t_entry                   w_out [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_hit;
    logic [TABLE_ENTRIES-1:0] w_common;

    assign o_stall  = (r_state == S_UPD);
    assign w_accept = i_valid && !o_stall;
    assign w_adv    = (r_state == S_UPD) && (!r_ov || !i_stall);

    assign w_insert     = (r_act == ACT_SECOND) || (r_act == ACT_THIRD);
    assign w_full       = (r_count == CNT_W'(TABLE_ENTRIES));
    assign w_any_hit    = |w_hit;
    assign w_any_common = |w_common;

    always_comb begin
        w_upd.clear         = w_adv && (r_act == ACT_CLEAR);
        w_upd.shift         = w_adv && w_insert && !w_any_hit && !w_full;
        w_upd.mark_second   = w_adv && (r_act == ACT_SECOND);
        w_upd.mark_third    = w_adv && (r_act == ACT_THIRD);
        w_upd.mark_reported = w_adv && (r_act == ACT_PROBE);
    end

    assign w_new.key      = $unsigned(r_val);
    assign w_new.valid    = 1'b1;
    assign w_new.second   = (r_act == ACT_SECOND);
    assign w_new.third    = (r_act == ACT_THIRD);
    assign w_new.reported = 1'b0;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            t_entry w_prev;
            if (g == 0) begin : g_head
                assign w_prev = w_new;
            end else begin : g_body
                assign w_prev = w_out[g-1];
            end
            tlce_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cmp_en (w_accept),
                .i_key    ($unsigned(i_item_value)),
                .i_upd    (w_upd),
                .i_prev   (w_prev),
                .o_entry  (w_out[g]),
                .o_hit    (w_hit[g]),
                .o_common (w_common[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_action;
            r_val <= i_item_value;
        end
        if (w_adv) begin
            r_o_val    <= r_val;
            r_o_common <= (r_act == ACT_PROBE) && w_any_common;
            r_o_status <= w_insert && !w_any_hit && w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_adv) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_upd.clear) begin
                r_count <= '0;
            end else if (w_upd.shift) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_adv) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_result_value = r_o_val;
    assign o_is_common    = r_o_common;
    assign o_status       = r_o_status;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

    import tlce_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    common;
        logic                    status;
    } t_answer;

    class common_tracker;
        logic [VAL_W-1:0] keys [TABLE_ENTRIES];
        bit               in_second [TABLE_ENTRIES];
        bit               in_third [TABLE_ENTRIES];
        bit               reported [TABLE_ENTRIES];
        int               used = 0;
        int               errors = 0;
        t_answer          awaited [$];

        function int lookup(logic [VAL_W-1:0] key);
            for (int i = 0; i < used; i++) begin
                if (keys[i] == key) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void note_item(logic [1:0] act, logic [VAL_W-1:0] key);
            t_answer a;
            int      idx;
            a.value  = key;
            a.common = 1'b0;
            a.status = 1'b0;
            case (act)
                ACT_CLEAR: begin
                    used = 0;
                end
                ACT_SECOND, ACT_THIRD: begin
                    idx = lookup(key);
                    if (idx < 0) begin
                        if (used < TABLE_ENTRIES) begin
                            idx            = used;
                            keys[idx]      = key;
                            in_second[idx] = 1'b0;
                            in_third[idx]  = 1'b0;
                            reported[idx]  = 1'b0;
                            used++;
                        end else begin
                            a.status = 1'b1;
                        end
                    end
                    if (idx >= 0) begin
                        if (act == ACT_SECOND) begin
                            in_second[idx] = 1'b1;
                        end else begin
                            in_third[idx] = 1'b1;
                        end
                    end
                end
                ACT_PROBE: begin
                    idx = lookup(key);
                    if (idx >= 0 && in_second[idx] && in_third[idx] && !reported[idx]) begin
                        a.common      = 1'b1;
                        reported[idx] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            awaited = {awaited, a};
        endfunction

        function void check_result(logic signed [VAL_W-1:0] value, logic common, logic status);
            t_answer a;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result value=%h common=%b status=%b",
                         $time, value, common, status);
                errors++;
                return;
            end
            a = awaited.pop_front();
            if ({value, common, status} !== {a.value, a.common, a.status}) begin
                $display("%0t: mismatch expected value=%h common=%b status=%b,",
                         $time, a.value, a.common, a.status,
                         " got value=%h common=%b status=%b", value, common, status);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [1:0]              i_action = ACT_CLEAR;
    logic signed [VAL_W-1:0] i_item_value = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [VAL_W-1:0] o_result_value;
    logic                    o_is_common;
    logic                    o_status;

    common_tracker tracker;
    bit            steady = 1'b0;
    int            items_sent = 0;
    int            cycle_count = 0;

    three_list_common_elements u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_item_value   (i_item_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_is_common    (o_is_common),
        .o_status       (o_status)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_result(o_result_value, o_is_common, o_status);
        end
        i_stall <= !steady && ($urandom_range(99) < 11);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input logic [1:0] act, input logic [VAL_W-1:0] value);
        while (!steady && $urandom_range(99) < 11) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_item_value <= value;
        do @(posedge i_clk); while (o_stall);
        tracker.note_item(act, value);
        items_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited.size() != 0);
    endtask

    task automatic run_episode(input bit fill_table);
        logic [VAL_W-1:0] pool [24];
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] v;
        logic [1:0]       act;
        int               n;
        int               m;
        int               r;
        if (fill_table) begin
            // fill every entry, then send new keys, known keys and probes against the full table
            drain_results();
            send_item(ACT_CLEAR, $urandom);
            base = $urandom;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                send_item($urandom_range(1) ? ACT_SECOND : ACT_THIRD, base + i);
            end
            for (int k = 0; k < 24; k++) begin
                r = $urandom_range(3);
                if (r == 0) begin
                    v = base + TABLE_ENTRIES + $urandom_range(1000);
                end else begin
                    v = base + $urandom_range(TABLE_ENTRIES - 1);
                end
                act = (r == 3) ? ACT_PROBE : ($urandom_range(1) ? ACT_SECOND : ACT_THIRD);
                send_item(act, v);
            end
            return;
        end
        if ($urandom_range(3) != 0) begin
            send_item(ACT_CLEAR, $urandom);
        end
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(7);
            if (r == 0) begin
                case ($urandom_range(3))
                    0: pool[i] = 32'h0000_0000;
                    1: pool[i] = 32'h7fff_ffff;
                    2: pool[i] = 32'h8000_0000;
                    default: pool[i] = 32'hffff_ffff;
                endcase
            end else if (r == 1 && i > 0) begin
                pool[i] = pool[0] ^ (32'd1 << $urandom_range(31));
            end else begin
                pool[i] = $urandom;
            end
        end
        m = $urandom_range(10, 60);
        for (int k = 0; k < m; k++) begin
            r = $urandom_range(99);
            v = pool[$urandom_range(n - 1)];
            if (r < 3) begin
                act = ACT_CLEAR;
            end else if (r < 13) begin
                act = 2'($urandom_range(ACT_SECOND, ACT_PROBE));
                v   = $urandom;
            end else if (r < 45) begin
                act = ACT_SECOND;
            end else if (r < 77) begin
                act = ACT_THIRD;
            end else begin
                act = ACT_PROBE;
            end
            send_item(act, v);
        end
    endtask

    initial begin
        int start;
        int episode;
        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(ACT_PROBE,  32'h0000_0000);
        send_item(ACT_SECOND, 32'h8000_0000);
        send_item(ACT_THIRD,  32'h8000_0000);
        send_item(ACT_PROBE,  32'h8000_0000);
        send_item(ACT_PROBE,  32'h8000_0000);
        send_item(ACT_SECOND, 32'h7fff_ffff);
        send_item(ACT_PROBE,  32'h7fff_ffff);
        send_item(ACT_THIRD,  32'h7fff_ffff);
        send_item(ACT_PROBE,  32'h7fff_ffff);
        send_item(ACT_SECOND, 32'h8000_0000);
        send_item(ACT_PROBE,  32'h8000_0000);
        send_item(ACT_SECOND, 32'hffff_ffff);
        send_item(ACT_SECOND, 32'hffff_ffff);
        send_item(ACT_THIRD,  32'h0000_0000);
        send_item(ACT_PROBE,  32'hffff_ffff);
        send_item(ACT_PROBE,  32'h0000_0000);
        send_item(ACT_THIRD,  32'hffff_ffff);
        send_item(ACT_PROBE,  32'hffff_ffff);
        send_item(ACT_SECOND, 32'h0000_0000);
        send_item(ACT_PROBE,  32'h0000_0000);
        send_item(ACT_CLEAR,  32'h1234_5678);
        send_item(ACT_PROBE,  32'h8000_0000);
        send_item(ACT_THIRD,  32'hffff_fffe);
        send_item(ACT_SECOND, 32'hffff_fffe);
        send_item(ACT_PROBE,  32'hffff_fffe);
        drain_results();

        start   = items_sent;
        episode = 0;
        while (items_sent < start + RANDOM_ITEMS) begin
            steady = (items_sent - start >= 700) && (items_sent - start < 1100);
            run_episode(episode % 10 == 3);
            episode++;
        end
        steady = 1'b0;

        drain_results();
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tlce_pkg.sv
rtl/tlce_cell.sv
rtl/three_list_common_elements.sv
dv/tb.sv
